>>> design/sed_pkg.sv
// sed_pkg: shared constants, types and the endpoint test for the skeleton endpoint detector
// depends on nothing; used by every other file of the block but sed_ram
package sed_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int PIX_W      = 8;
    localparam int WREG_W     = 12;
    localparam int HREG_W     = 13;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;

    localparam logic [PIX_W-1:0] WHITE_LEVEL = 8'd255;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

    localparam logic [WREG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [HREG_W-1:0] HEIGHT_RESET = 13'd480;

    // job queue between front and back
    localparam int QDEPTH = 8;
    localparam int Q_AW   = $clog2(QDEPTH);
    localparam int QCNT_W = Q_AW + 1;

    // one job: a window and the centers it reports
    // mask bit order: (r-1,c-1), (r-1,c), (r,c-1), (r,c)
    typedef struct packed {
        logic [8:0]       win;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [3:0]       mask;
        logic             frame_end;
    } t_job;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } t_q_stat;

    // window bit at row slot y, column slot x; slots past 2 are outside
    function automatic logic win_bit(input logic [8:0] win, input logic [2:0] y,
                                     input logic [2:0] x);
        logic [3:0] idx;
        idx = 4'(x * 3 + y);
        if (y > 3'd2 || x > 3'd2) begin
            return 1'b0;
        end
        return win[idx];
    endfunction

    function automatic logic endpoint_at(input logic [8:0] win, input logic [1:0] y,
                                         input logic [1:0] x);
        logic [3:0] n;
        logic [2:0] yy;
        logic [2:0] xx;
        n = '0;
        if (!win_bit(win, {1'b0, y}, {1'b0, x})) begin
            return 1'b0;
        end
        for (int dy = 0; dy < 3; dy++) begin
            for (int dx = 0; dx < 3; dx++) begin
                yy = {1'b0, y} + 3'(dy) - 3'd1;
                xx = {1'b0, x} + 3'(dx) - 3'd1;
                if (!(dy == 1 && dx == 1)) begin
                    n = n + {3'b000, win_bit(win, yy, xx)};
                end
            end
        end
        return (n == 4'd1);
    endfunction

endpackage

>>> design/sed_if.sv
// sed_if: valid/ready channel interfaces for pixels, results and register writes
// depends on sed_pkg for field widths
interface sed_pix_if;
    logic                       valid;
    logic                       ready;
    logic [sed_pkg::PIX_W-1:0]  pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface sed_res_if;
    logic                       valid;
    logic                       ready;
    logic [sed_pkg::ROW_W-1:0]  center_row;
    logic [sed_pkg::COL_W-1:0]  center_col;
    logic                       is_endpoint;
    logic                       last_of_run;
    logic                       frame_done;

    modport source (output valid, output center_row, output center_col,
                    output is_endpoint, output last_of_run, output frame_done,
                    input ready);
    modport sink   (input valid, input center_row, input center_col,
                    input is_endpoint, input last_of_run, input frame_done,
                    output ready);
endinterface

interface sed_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sed_pkg::CFG_IDX_W-1:0]  index;
    logic [sed_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/sed_ram.sv
// sed_ram: generic simple dual-port ram, one write and one registered read port
// read during write to the same address returns the old data; no dependencies
module sed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

endmodule

>>> design/sed_front.sv
// sed_front: register port, pixel intake, line store and 3x3 window; at most one job per pixel
// depends on sed_pkg, sed_if and sed_ram
module sed_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sed_pix_if.sink          i_pix,
    sed_cfg_if.sink          i_cfg,
    input  sed_pkg::t_q_stat i_qstat,
    output logic             o_push,
    output sed_pkg::t_job    o_job
);
    import sed_pkg::*;

    logic [WREG_W-1:0] r_width;
    logic [HREG_W-1:0] r_height;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic              r_clr;
    logic [COL_W-1:0]  r_clr_addr;

    logic              r_s1_valid;
    logic              r_s1_cur;
    logic [ROW_W-1:0]  r_s1_row;
    logic [COL_W-1:0]  r_s1_col;
    logic              r_s1_last_c;
    logic              r_s1_last_r;
    logic [8:0]        r_win;

    logic              r_wb_valid;
    logic [COL_W-1:0]  r_wb_addr;
    logic [1:0]        r_wb_data;

    logic [COL_W:0]    w_eff;
    logic [COL_W:0]    w_m1;
    logic [ROW_W:0]    h_eff;
    logic [ROW_W:0]    h_m1;
    logic [COL_W-1:0]  c_eff;
    logic [ROW_W-1:0]  r_eff;
    logic              last_c;
    logic              last_r;
    logic              accept;
    logic [QCNT_W:0]   in_flight;

    logic [1:0]        ram_rdata;
    logic [1:0]        raw;
    logic              above;
    logic              two;
    logic [8:0]        prev;
    logic [8:0]        n_win;
    logic [3:0]        mask;
    logic              ram_we;
    logic [COL_W-1:0]  ram_waddr;
    logic [1:0]        ram_wdata;

    // clamp configured sizes to the supported range
    assign w_eff = (r_width == '0) ? (COL_W+1)'(1) :
                   (r_width > WREG_W'(MAX_WIDTH)) ? (COL_W+1)'(MAX_WIDTH) :
                   (COL_W+1)'(r_width);
    assign h_eff = (r_height == '0) ? (ROW_W+1)'(1) :
                   (r_height > HREG_W'(MAX_HEIGHT)) ? (ROW_W+1)'(MAX_HEIGHT) :
                   (ROW_W+1)'(r_height);
    assign w_m1  = w_eff - (COL_W+1)'(1);
    assign h_m1  = h_eff - (ROW_W+1)'(1);
    assign c_eff = ({1'b0, r_col} >= w_eff) ? COL_W'(w_m1) : r_col;
    assign r_eff = ({1'b0, r_row} >= h_eff) ? ROW_W'(h_m1) : r_row;
    assign last_c = ({1'b0, c_eff} == w_m1);
    assign last_r = ({1'b0, r_eff} == h_m1);

    // room in the queue for this item and the one still in the window stage
    assign in_flight   = (QCNT_W+1)'(i_qstat.count) + (QCNT_W+1)'(r_s1_valid);
    assign i_pix.ready = !r_clr && (in_flight < (QCNT_W+1)'(QDEPTH));
    assign accept      = i_pix.valid && i_pix.ready;
    assign i_cfg.ready = 1'b1;

    // line store entry: bit 1 two rows above, bit 0 one row above
    sed_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (c_eff),
        .o_rdata (ram_rdata)
    );

    // same column written in the previous cycle: ram returned the stale entry
    assign raw   = (r_wb_valid && r_wb_addr == r_s1_col) ? r_wb_data : ram_rdata;
    assign above = (r_s1_row >= ROW_W'(1)) ? raw[0] : 1'b0;
    assign two   = (r_s1_row >= ROW_W'(2)) ? raw[1] : 1'b0;
    assign prev  = (r_s1_col == '0) ? 9'd0 : r_win;
    assign n_win = {r_s1_cur, above, two, prev[8:3]};

    assign ram_we    = r_clr || r_s1_valid;
    assign ram_waddr = r_clr ? r_clr_addr : r_s1_col;
    assign ram_wdata = r_clr ? 2'b00 : {raw[0], r_s1_cur};

    assign mask[0] = (r_s1_row != '0) && (r_s1_col != '0);
    assign mask[1] = (r_s1_row != '0) && r_s1_last_c;
    assign mask[2] = r_s1_last_r && (r_s1_col != '0);
    assign mask[3] = r_s1_last_r && r_s1_last_c;

    assign o_push          = r_s1_valid && (mask != 4'd0);
    assign o_job.win       = n_win;
    assign o_job.row       = r_s1_row;
    assign o_job.col       = r_s1_col;
    assign o_job.mask      = mask;
    assign o_job.frame_end = r_s1_last_r && r_s1_last_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WIDTH_RESET;
            r_height    <= HEIGHT_RESET;
            r_row       <= '0;
            r_col       <= '0;
            r_clr       <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_win       <= '0;
            r_wb_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    REG_IMAGE_WIDTH:  r_width  <= i_cfg.data[WREG_W-1:0];
                    REG_IMAGE_HEIGHT: r_height <= i_cfg.data[HREG_W-1:0];
                    default: ;
                endcase
            end
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + COL_W'(1);
                if (r_clr_addr == COL_W'(MAX_WIDTH - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            if (accept) begin
                if (last_c) begin
                    r_col <= '0;
                    r_row <= last_r ? '0 : r_eff + ROW_W'(1);
                end else begin
                    r_col <= c_eff + COL_W'(1);
                    r_row <= r_eff;
                end
            end
            r_s1_valid <= accept;
            r_wb_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cur    <= (i_pix.pixel == WHITE_LEVEL);
            r_s1_row    <= r_eff;
            r_s1_col    <= c_eff;
            r_s1_last_c <= last_c;
            r_s1_last_r <= last_r;
        end
        r_wb_addr <= r_s1_col;
        r_wb_data <= ram_wdata;
    end

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (i_qstat.count < QCNT_W'(QDEPTH)))
        else $error("job pushed into a full queue");

    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_clr |=> !r_clr)
        else $error("line store clearing restarted");

endmodule

>>> design/sed_queue.sv
// sed_queue: short job queue between the front and the back
// depends on sed_pkg
module sed_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sed_pkg::t_job    i_job,
    input  logic             i_pop,
    output sed_pkg::t_job    o_job,
    output sed_pkg::t_q_stat o_stat
);
    import sed_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_job        = r_mem[r_rd_ptr];
    assign o_stat.count = r_count;
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from an empty queue");

endmodule

>>> design/sed_back.sv
// sed_back: expands jobs into output-register results, one per cycle unless stalled
// depends on sed_pkg and sed_if
module sed_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sed_pkg::t_q_stat i_qstat,
    input  sed_pkg::t_job    i_job,
    output logic             o_pop,
    sed_res_if.source        o_res
);
    import sed_pkg::*;

    logic             r_busy;
    t_job             r_job;
    logic [3:0]       r_mask;
    logic             r_ov;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic             r_ep;
    logic             r_last;
    logic             r_fdone;

    logic             emit;
    logic [3:0]       low;
    logic [3:0]       rem;
    logic [1:0]       sel;
    logic [1:0]       ys;
    logic [1:0]       xs;

    assign emit = r_busy && (!r_ov || o_res.ready);
    assign low  = r_mask & (~r_mask + 4'd1);
    assign rem  = r_mask & ~low;

    always_comb begin
        unique case (low)
            4'b0001: sel = 2'd0;
            4'b0010: sel = 2'd1;
            4'b0100: sel = 2'd2;
            4'b1000: sel = 2'd3;
            default: sel = 2'd0;
        endcase
    end

    // slot bit 1 picks the centre row, bit 0 the centre column
    assign ys = sel[1] ? 2'd2 : 2'd1;
    assign xs = sel[0] ? 2'd2 : 2'd1;

    assign o_pop = !i_qstat.empty && (!r_busy || (emit && rem == 4'd0));

    assign o_res.valid       = r_ov;
    assign o_res.center_row  = r_row;
    assign o_res.center_col  = r_col;
    assign o_res.is_endpoint = r_ep;
    assign o_res.last_of_run = r_last;
    assign o_res.frame_done  = r_fdone;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (emit && rem == 4'd0) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job  <= i_job;
            r_mask <= i_job.mask;
        end else if (emit) begin
            r_mask <= rem;
        end
        if (emit) begin
            r_row   <= sel[1] ? r_job.row : r_job.row - ROW_W'(1);
            r_col   <= sel[0] ? r_job.col : r_job.col - COL_W'(1);
            r_ep    <= endpoint_at(r_job.win, ys, xs);
            r_last  <= (rem == 4'd0);
            r_fdone <= (rem == 4'd0) && r_job.frame_end;
        end
    end

    a_busy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_mask != 4'd0))
        else $error("back busy with no result left");

    a_frame_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.frame_done) |-> o_res.last_of_run)
        else $error("frame end not on the last result of its item");

endmodule

>>> design/skeleton_endpoint_detect_top.sv
// Streaming 3x3 skeleton endpoint detector. One pixel item is accepted per clock in raster
// order while the queue has room; each item enters a line store read/write stage (dual-port
// ram, one column per cycle) and is turned into a job that holds its window and the centres
// it reports. An item makes zero to four results: one in the middle of the frame, two at a
// row's last pixel or along the last row, four for the final pixel. The back end sends one
// result per cycle while the output is ready; an 8-entry job queue lets pixel intake run on
// while the back end drains; intake stalls only when the queue fills or while the line
// store is cleared after reset, during which no pixel is accepted; register writes
// are taken at any time.
// depends on sed_pkg, sed_if, sed_front, sed_queue and sed_back
module skeleton_endpoint_detect_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sed_pix_if.sink   i_pix,
    sed_cfg_if.sink   i_cfg,
    sed_res_if.source o_res
);
    import sed_pkg::*;

    logic    push;
    logic    pop;
    t_job    push_job;
    t_job    head_job;
    t_q_stat qstat;

    sed_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_cfg   (i_cfg),
        .i_qstat (qstat),
        .o_push  (push),
        .o_job   (push_job)
    );

    sed_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (qstat)
    );

    sed_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (qstat),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

>>> sim/skeleton_endpoint_detect_top_tb.sv
// testbench for skeleton_endpoint_detect_top: streams gray pixel items through frames of
// many shapes and checks every reported window centre against a bit-exact predictor
// depends on sed_pkg, sed_if and the block's rtl
module skeleton_endpoint_detect_top_tb;
    import sed_pkg::*;

    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int RANDOM_ITEMS   = 270;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             endpoint;
        logic             last_of_run;
        logic             frame_done;
    } t_center_result;

    class endpoint_scoreboard;
        bit               line_above[MAX_WIDTH];
        bit               line_two_above[MAX_WIDTH];
        bit [8:0]         window;
        int unsigned      row;
        int unsigned      col;
        bit [WREG_W-1:0]  width_reg;
        bit [HREG_W-1:0]  height_reg;
        t_center_result   pending[$];
        int               errors;

        function new();
            foreach (line_above[i]) begin
                line_above[i]     = 1'b0;
                line_two_above[i] = 1'b0;
            end
            window     = '0;
            row        = 0;
            col        = 0;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            errors     = 0;
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_IMAGE_WIDTH) begin
                width_reg = data[WREG_W-1:0];
            end else if (idx == REG_IMAGE_HEIGHT) begin
                height_reg = data[HREG_W-1:0];
            end
        endfunction

        // slots: x = column (0 oldest), y = row (0 = two above); outside slots are black
        function bit win_at(bit [8:0] win, int y, int x);
            if (y < 0 || y > 2 || x < 0 || x > 2) begin
                return 1'b0;
            end
            return win[x * 3 + y];
        endfunction

        function bit is_end(bit [8:0] win, int y, int x);
            int n;
            n = 0;
            if (!win_at(win, y, x)) begin
                return 1'b0;
            end
            for (int dy = -1; dy <= 1; dy++) begin
                for (int dx = -1; dx <= 1; dx++) begin
                    if (dy != 0 || dx != 0) begin
                        n += win_at(win, y + dy, x + dx);
                    end
                end
            end
            return n == 1;
        endfunction

        function void note_pixel(logic [PIX_W-1:0] value);
            int unsigned    w, h, r, c;
            bit             cur, up1, up2, last_c, last_r;
            bit [8:0]       prev;
            int             ys[2], xs[2];
            int             ny, nx, total, k;
            t_center_result item;
            w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
            h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
            r = (row >= h) ? h - 1 : row;
            c = (col >= w) ? w - 1 : col;

            cur = (value == WHITE_LEVEL);
            up1 = (r >= 1) ? line_above[c] : 1'b0;
            up2 = (r >= 2) ? line_two_above[c] : 1'b0;
            line_two_above[c] = line_above[c];
            line_above[c]     = cur;

            // a new row starts with an all-black window
            prev   = (c == 0) ? 9'd0 : window;
            window = {cur, up1, up2, prev[8:3]};

            last_c = (c + 1 >= w);
            last_r = (r + 1 >= h);
            ny = 0;
            nx = 0;
            if (r >= 1) begin
                ys[ny++] = 1;
            end
            if (last_r) begin
                ys[ny++] = 2;
            end
            if (c >= 1) begin
                xs[nx++] = 1;
            end
            if (last_c) begin
                xs[nx++] = 2;
            end
            total = ny * nx;
            k = 0;
            for (int iy = 0; iy < ny; iy++) begin
                for (int ix = 0; ix < nx; ix++) begin
                    item.row         = ROW_W'(r + ys[iy] - 2);
                    item.col         = COL_W'(c + xs[ix] - 2);
                    item.endpoint    = is_end(window, ys[iy], xs[ix]);
                    item.last_of_run = (k == total - 1);
                    item.frame_done  = (k == total - 1) && last_r && last_c;
                    pending.push_back(item);
                    k++;
                end
            end

            if (last_c) begin
                col = 0;
                row = last_r ? 0 : r + 1;
            end else begin
                col = c + 1;
                row = r;
            end
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_center_result got);
            t_center_result want;
            if (pending.size() == 0) begin
                report($sformatf("result row %0d col %0d with none expected",
                                 got.row, got.col));
                return;
            end
            want = pending.pop_front();
            if (got.row !== want.row) begin
                report($sformatf("center_row %0d, want %0d", got.row, want.row));
            end
            if (got.col !== want.col) begin
                report($sformatf("center_col %0d, want %0d", got.col, want.col));
            end
            if (got.endpoint !== want.endpoint) begin
                report($sformatf("is_endpoint %b at (%0d,%0d), want %b",
                                 got.endpoint, want.row, want.col, want.endpoint));
            end
            if (got.last_of_run !== want.last_of_run) begin
                report($sformatf("last_of_run %b at (%0d,%0d), want %b",
                                 got.last_of_run, want.row, want.col, want.last_of_run));
            end
            if (got.frame_done !== want.frame_done) begin
                report($sformatf("frame_done %b at (%0d,%0d), want %b",
                                 got.frame_done, want.row, want.col, want.frame_done));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    sed_pix_if pix();
    sed_cfg_if cfg();
    sed_res_if res();

    skeleton_endpoint_detect_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    endpoint_scoreboard sb;
    bit                 quiet;
    int                 idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // items are taken from all three channels at the same edge the block sees them
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg.valid && cfg.ready) begin
                sb.note_config(cfg.index, cfg.data);
            end
            if (pix.valid && pix.ready) begin
                sb.note_pixel(pix.pixel);
            end
            if (res.valid && res.ready) begin
                sb.check_result({res.center_row, res.center_col, res.is_endpoint,
                                 res.last_of_run, res.frame_done});
            end
        end
    end

    always @(posedge i_clk) begin
        if ((pix.valid && pix.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
        begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("FAIL skeleton_endpoint_detect_top");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result sink with random stalls
    initial begin
        int stall;
        res.ready <= 1'b0;
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res.ready <= 1'b1;
            do @(posedge i_clk); while (res.valid !== 1'b1);
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] value);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.pixel <= value;
        do @(posedge i_clk); while (pix.ready !== 1'b1);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge i_clk); while (cfg.ready !== 1'b1);
        cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        pix.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
    endtask

    // row-0 and column-0 items make no result, so give the pipeline time to empty
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly skeleton-like black/white, some gray noise
    function automatic logic [PIX_W-1:0] draw_pixel();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 3) begin
            return WHITE_LEVEL;
        end else if (pick <= 6) begin
            return '0;
        end else if (pick == 7) begin
            return PIX_W'(WHITE_LEVEL - 1);
        end
        return PIX_W'($urandom_range(0, 255));
    endfunction

    initial begin
        logic [PIX_W-1:0] diag_frame[9];
        int unsigned      w_val, h_val, w_eff, h_eff, n_items, sent, pick;
        sb = new();
        quiet       = 1'b0;
        idle_cycles = 0;
        pix.valid <= 1'b0;
        pix.pixel <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= REG_IMAGE_WIDTH;
        cfg.data  <= '0;
        i_rst_n   <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 3x3 diagonal: row 0 and column 0 must count as neighbours
        diag_frame = '{8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd254};
        write_reg(REG_IMAGE_WIDTH, 13'd3);
        write_reg(REG_IMAGE_HEIGHT, 13'd3);
        foreach (diag_frame[i]) begin
            send_pixel(diag_frame[i]);
        end

        // zero width (upper data bit is dropped) and zero height act as 1x1
        settle();
        write_reg(REG_IMAGE_WIDTH, 13'h1000);
        write_reg(REG_IMAGE_HEIGHT, 13'd0);
        send_pixel(8'd255);
        send_pixel(8'd0);

        // saturated sizes, then shrink the frame under the running counters
        settle();
        write_reg(REG_IMAGE_WIDTH, 13'd4095);
        write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd128);
        send_pixel(8'd1);
        settle();
        write_reg(REG_IMAGE_WIDTH, 13'd2);
        send_pixel(8'd255);
        send_pixel(8'd127);
        send_pixel(8'd255);
        settle();
        write_reg(REG_IMAGE_HEIGHT, 13'd1);
        send_pixel(8'd255);
        send_pixel(8'd255);

        w_val = 2;
        h_val = 1;
        sent  = 0;
        while (sent < RANDOM_ITEMS) begin
            settle();
            pick = $urandom_range(0, 4);
            if (pick != 1) begin
                case ($urandom_range(0, 9))
                    0: w_val = 0;
                    9: w_val = $urandom_range(13, 40);
                    default: w_val = $urandom_range(1, 12);
                endcase
                write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w_val));
            end
            w_eff = (w_val == 0) ? 1 : w_val;
            if (pick != 0) begin
                if ($urandom_range(0, 9) == 0) begin
                    h_val = 0;
                end else begin
                    h_val = (w_eff > 12) ? $urandom_range(1, 2) : $urandom_range(1, 6);
                end
                write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h_val));
            end
            h_eff = (h_val == 0) ? 1 : h_val;

            n_items = w_eff * h_eff;
            if (n_items <= 20 && $urandom_range(0, 1) == 1) begin
                n_items = 2 * n_items;
            end
            if (n_items > 96) begin
                n_items = 96;
            end
            // broken frames leave the counters mid-frame for the next setting
            if ($urandom_range(0, 4) == 0) begin
                n_items = $urandom_range(1, n_items);
            end
            quiet = ($urandom_range(0, 3) == 0);

            for (int unsigned i = 0; i < n_items; i++) begin
                if ($urandom_range(0, 49) == 0) begin
                    drain();
                end
                send_pixel(draw_pixel());
                sent++;
            end
            quiet = 1'b0;
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("PASS skeleton_endpoint_detect_top");
        end else begin
            $display("FAIL skeleton_endpoint_detect_top");
        end
        $finish;
    end

endmodule
